[rtl/bpa_pkg.sv]
`timescale 1ns / 1ps
package bpa_pkg;

  localparam int MAX_ORDER    = 10;
  localparam int PAGE_SHIFT   = 12;
  localparam int LEVELS       = MAX_ORDER + 1;
  localparam int NODES        = (1 << (MAX_ORDER + 1)) - 1;
  localparam int LINKS        = NODES + LEVELS;
  localparam int LINK_W       = $clog2(LINKS);
  localparam int NODE_W       = $clog2(NODES);
  localparam int LVL_W        = $clog2(LEVELS);
  localparam int CNT_W        = MAX_ORDER + 1;
  localparam int ADDR_W       = 48;
  localparam int COUNT_W      = 16;
  localparam int FLVL_W       = 5;
  localparam int REGION_SHIFT = PAGE_SHIFT + MAX_ORDER;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_FREE = 2'd1,
    STAT_NO_BLOCK = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE,
    S_A_CHK, S_A_TAIL, S_A_SRCH, S_A_SRCHRET, S_A_POPD,
    S_A_SPL, S_A_SPL2, S_A_SPL3, S_A_SPL4, S_A_IDX, S_A_ADD,
    S_F_CHK, S_F_POS, S_F_RD, S_F_TST,
    S_M_RDB, S_M_RDO, S_M_TST, S_M_POP, S_M_PUSH,
    S_UL0, S_UL1, S_PU0, S_PU1, S_PU2,
    S_OUT
  } state_t;

  typedef struct packed {
    logic                  op;
    logic [COUNT_W-1:0]    page_count;
    logic [ADDR_W-1:0]     block_address;
    logic [FLVL_W-1:0]     free_level;
  } bpa_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_address;
    status_t           status;
  } bpa_rsp_t;

  // List head entry of a level
  function automatic logic [LINK_W-1:0] head_of(input logic [LVL_W-1:0] l);
    return LINK_W'(NODES) + LINK_W'(l);
  endfunction

  // Smallest k with 2^k >= v
  function automatic logic [LVL_W-1:0] order_of(input logic [COUNT_W-1:0] v);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int i = MAX_ORDER; i >= 0; i--) begin
      if ((17'(1) << i) >= 17'(v)) r = LVL_W'(i);
    end
    return r;
  endfunction

  function automatic logic [LINK_W-1:0] buddy_of(input logic [LINK_W-1:0] off);
    logic [LINK_W-1:0] r;
    if (off == '0) r = '0;
    else if (off[0]) r = off + LINK_W'(1);
    else r = off - LINK_W'(1);
    return r;
  endfunction

endpackage

[rtl/bpa_core.sv]
`timescale 1ns / 1ps
module bpa_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_ready,
  input  bpa_pkg::bpa_req_t       req,
  input  logic [bpa_pkg::ADDR_W-1:0] base_address,
  output logic                    rsp_valid,
  input  logic                    rsp_ready,
  output bpa_pkg::bpa_rsp_t       rsp
);
  import bpa_pkg::*;

  // Link and free-mark memories
  logic [LINK_W-1:0] prev_mem [LINKS];
  logic [LINK_W-1:0] next_mem [LINKS];
  logic              free_mem [NODES];

  logic              prev_we, next_we, free_we;
  logic [LINK_W-1:0] prev_wa, next_wa, prev_wd, next_wd;
  logic [LINK_W-1:0] free_wa;
  logic              free_wd;
  logic [LINK_W-1:0] prev_ra, next_ra, free_ra;
  logic [LINK_W-1:0] prev_q, next_q;
  logic              free_q;

  // Per-level tail and count
  logic [LINK_W-1:0] tail [LEVELS];
  logic [LINK_W-1:0] tail_next [LEVELS];
  logic [CNT_W-1:0]  cnt [LEVELS];
  logic [CNT_W-1:0]  cnt_next [LEVELS];

  state_t            state, state_next, ret, ret_next;
  bpa_req_t          rq, rq_next;
  logic [LINK_W-1:0] clr_cnt, clr_cnt_next;
  logic [LVL_W-1:0]  lvl, lvl_next, cur, cur_next, splits, splits_next;
  logic [LVL_W-1:0]  sub_lvl, sub_lvl_next;
  logic [LINK_W-1:0] blk, blk_next, e, e_next, sub_t, sub_t_next, nt, nt_next;
  logic [LINK_W-1:0] off, off_next;
  logic              pop_flag, pop_flag_next, bfree, bfree_next;
  logic [ADDR_W-1:0] rel, rel_next;
  bpa_rsp_t          res, res_next;

  always_ff @(posedge clk) begin
    if (prev_we && prev_wa < LINK_W'(LINKS)) prev_mem[prev_wa] <= prev_wd;
    if (next_we && next_wa < LINK_W'(LINKS)) next_mem[next_wa] <= next_wd;
    if (free_we && free_wa < LINK_W'(NODES)) free_mem[free_wa[NODE_W-1:0]] <= free_wd;
    prev_q <= (prev_ra < LINK_W'(LINKS)) ? prev_mem[prev_ra] : '0;
    next_q <= (next_ra < LINK_W'(LINKS)) ? next_mem[next_ra] : '0;
    free_q <= (free_ra < LINK_W'(NODES)) ? free_mem[free_ra[NODE_W-1:0]] : 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr_cnt <= '0;
      for (int i = 0; i < LEVELS; i++) begin
        tail[i] <= (i == 0) ? '0 : head_of(LVL_W'(i));
        cnt[i]  <= (i == 0) ? CNT_W'(1) : '0;
      end
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
      tail    <= tail_next;
      cnt     <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    ret      <= ret_next;
    rq       <= rq_next;
    lvl      <= lvl_next;
    cur      <= cur_next;
    splits   <= splits_next;
    sub_lvl  <= sub_lvl_next;
    blk      <= blk_next;
    e        <= e_next;
    sub_t    <= sub_t_next;
    nt       <= nt_next;
    off      <= off_next;
    pop_flag <= pop_flag_next;
    bfree    <= bfree_next;
    rel      <= rel_next;
    res      <= res_next;
  end

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_OUT);
  assign rsp       = res;

  always_comb begin
    logic [LVL_W-1:0]  l1;
    logic [21:0]       pos;
    logic [31:0]       idx;
    logic [LINK_W-1:0] init_v, noff;
    state_next    = state;
    ret_next      = ret;
    rq_next       = rq;
    clr_cnt_next  = clr_cnt;
    lvl_next      = lvl;
    cur_next      = cur;
    splits_next   = splits;
    sub_lvl_next  = sub_lvl;
    blk_next      = blk;
    e_next        = e;
    sub_t_next    = sub_t;
    nt_next       = nt;
    off_next      = off;
    pop_flag_next = pop_flag;
    bfree_next    = bfree;
    rel_next      = rel;
    res_next      = res;
    tail_next     = tail;
    cnt_next      = cnt;
    prev_we = 1'b0; prev_wa = '0; prev_wd = '0;
    next_we = 1'b0; next_wa = '0; next_wd = '0;
    free_we = 1'b0; free_wa = '0; free_wd = 1'b0;
    prev_ra = '0; next_ra = '0; free_ra = '0;
    l1     = lvl - LVL_W'(1);
    pos    = '0;
    idx    = '0;
    init_v = '0;
    noff   = '0;

    case (state)
      // Clearing pass over the link and free memories
      S_CLR: begin
        if (clr_cnt == '0) init_v = head_of('0);
        else if (clr_cnt == head_of('0)) init_v = '0;
        else if (clr_cnt > head_of('0)) init_v = clr_cnt;
        prev_we = 1'b1; prev_wa = clr_cnt; prev_wd = init_v;
        next_we = 1'b1; next_wa = clr_cnt; next_wd = init_v;
        free_we = 1'b1; free_wa = clr_cnt; free_wd = (clr_cnt == '0);
        clr_cnt_next = clr_cnt + LINK_W'(1);
        if (clr_cnt == LINK_W'(LINKS - 1)) state_next = S_IDLE;
      end

      S_IDLE: begin
        if (req_valid) begin
          rq_next    = req;
          state_next = req.op ? S_F_CHK : S_A_CHK;
        end
      end

      // Allocate: round up and pick the level
      S_A_CHK: begin
        if (rq.page_count == '0 || 17'(rq.page_count) > (17'(1) << MAX_ORDER)) begin
          res_next   = '{result_address: '0, status: STAT_NO_BLOCK};
          state_next = S_OUT;
        end else begin
          lvl_next   = LVL_W'(MAX_ORDER) - order_of(rq.page_count);
          state_next = S_A_TAIL;
        end
      end

      S_A_TAIL: begin
        blk_next    = tail[lvl];
        splits_next = '0;
        state_next  = S_A_SRCH;
      end

      // Walk up until a level with a free block
      S_A_SRCH: begin
        if (lvl != '0 && blk == head_of(lvl)) begin
          lvl_next    = l1;
          splits_next = splits + LVL_W'(1);
          if (cnt[l1] == '0) begin
            blk_next = head_of(l1);
          end else begin
            e_next        = tail[l1];
            sub_lvl_next  = l1;
            pop_flag_next = 1'b1;
            ret_next      = S_A_SRCHRET;
            state_next    = S_UL0;
          end
        end else if (blk >= LINK_W'(NODES)) begin
          res_next   = '{result_address: '0, status: STAT_NO_BLOCK};
          state_next = S_OUT;
        end else if (splits == '0) begin
          if (cnt[lvl] == '0) begin
            res_next   = '{result_address: '0, status: STAT_NO_BLOCK};
            state_next = S_OUT;
          end else begin
            e_next        = tail[lvl];
            sub_lvl_next  = lvl;
            pop_flag_next = 1'b1;
            ret_next      = S_A_POPD;
            state_next    = S_UL0;
          end
        end else begin
          cur_next   = lvl;
          state_next = S_A_SPL;
        end
      end

      S_A_SRCHRET: begin
        blk_next   = e;
        state_next = S_A_SRCH;
      end

      S_A_POPD: begin
        blk_next = e;
        cur_next = lvl;
        if (e >= LINK_W'(NODES)) begin
          res_next   = '{result_address: '0, status: STAT_NO_BLOCK};
          state_next = S_OUT;
        end else begin
          state_next = S_A_IDX;
        end
      end

      // Split down: push right, push left, pop left
      S_A_SPL: begin
        if (cur == lvl + splits) begin
          state_next = S_A_IDX;
        end else begin
          e_next       = {blk[LINK_W-2:0], 1'b0} + LINK_W'(2);
          sub_lvl_next = cur + LVL_W'(1);
          ret_next     = S_A_SPL2;
          state_next   = S_PU0;
        end
      end

      S_A_SPL2: begin
        e_next     = {blk[LINK_W-2:0], 1'b1};
        ret_next   = S_A_SPL3;
        state_next = S_PU0;
      end

      S_A_SPL3: begin
        if (cnt[sub_lvl] == '0) begin
          blk_next   = head_of(sub_lvl);
          cur_next   = sub_lvl;
          state_next = S_A_SPL;
        end else begin
          e_next        = tail[sub_lvl];
          pop_flag_next = 1'b1;
          ret_next      = S_A_SPL4;
          state_next    = S_UL0;
        end
      end

      S_A_SPL4: begin
        blk_next   = e;
        cur_next   = cur + LVL_W'(1);
        state_next = S_A_SPL;
      end

      // Block offset inside the region
      S_A_IDX: begin
        idx        = 32'(blk) + 32'd1 - (32'd1 << cur);
        rel_next   = ADDR_W'(idx) << (REGION_SHIFT - 32'(cur));
        state_next = S_A_ADD;
      end

      S_A_ADD: begin
        res_next   = '{result_address: base_address + rel, status: STAT_OK};
        state_next = S_OUT;
      end

      // Free: address checks
      S_F_CHK: begin
        if (rq.free_level > FLVL_W'(MAX_ORDER) || rq.block_address < base_address ||
            rq.block_address[PAGE_SHIFT-1:0] != '0) begin
          res_next   = '{result_address: '0, status: STAT_BAD_FREE};
          state_next = S_OUT;
        end else begin
          rel_next   = rq.block_address - base_address;
          state_next = S_F_POS;
        end
      end

      S_F_POS: begin
        if (rel[ADDR_W-1:REGION_SHIFT] != '0) begin
          res_next   = '{result_address: '0, status: STAT_BAD_FREE};
          state_next = S_OUT;
        end else begin
          pos        = rel[REGION_SHIFT-1:0] >> (REGION_SHIFT - 32'(rq.free_level));
          lvl_next   = rq.free_level[LVL_W-1:0];
          off_next   = (LINK_W'(1) << rq.free_level) - LINK_W'(1) + pos[LINK_W-1:0];
          state_next = S_F_RD;
        end
      end

      S_F_RD: begin
        free_ra    = off;
        state_next = S_F_TST;
      end

      S_F_TST: begin
        if (free_q) begin
          res_next   = '{result_address: '0, status: STAT_BAD_FREE};
          state_next = S_OUT;
        end else begin
          e_next       = off;
          sub_lvl_next = lvl;
          ret_next     = S_M_RDB;
          state_next   = S_PU0;
        end
      end

      // Merge upward while the buddy is free
      S_M_RDB: begin
        if (lvl == '0) begin
          res_next   = '{result_address: '0, status: STAT_OK};
          state_next = S_OUT;
        end else begin
          free_ra    = buddy_of(off);
          state_next = S_M_RDO;
        end
      end

      S_M_RDO: begin
        bfree_next = free_q;
        free_ra    = off;
        state_next = S_M_TST;
      end

      S_M_TST: begin
        if (bfree && free_q) begin
          e_next        = buddy_of(off);
          sub_lvl_next  = lvl;
          pop_flag_next = 1'b0;
          ret_next      = S_M_POP;
          state_next    = S_UL0;
        end else begin
          res_next   = '{result_address: '0, status: STAT_OK};
          state_next = S_OUT;
        end
      end

      S_M_POP: begin
        if (cnt[lvl] == '0) begin
          state_next = S_M_PUSH;
        end else begin
          e_next        = tail[lvl];
          sub_lvl_next  = lvl;
          pop_flag_next = 1'b1;
          ret_next      = S_M_PUSH;
          state_next    = S_UL0;
        end
      end

      S_M_PUSH: begin
        noff         = (off - LINK_W'(1)) >> 1;
        off_next     = noff;
        e_next       = noff;
        sub_lvl_next = l1;
        lvl_next     = l1;
        ret_next     = S_M_RDB;
        state_next   = S_PU0;
      end

      // Unlink entry e from list sub_lvl; pop also moves the tail
      S_UL0: begin
        free_we    = 1'b1; free_wa = e; free_wd = 1'b0;
        prev_ra    = e;
        next_ra    = e;
        state_next = S_UL1;
      end

      S_UL1: begin
        next_we = 1'b1; next_wa = prev_q; next_wd = next_q;
        prev_we = 1'b1; prev_wa = next_q; prev_wd = prev_q;
        cnt_next[sub_lvl] = cnt[sub_lvl] - CNT_W'(1);
        if (pop_flag) tail_next[sub_lvl] = prev_q;
        state_next = ret;
      end

      // Push entry e after the tail of list sub_lvl
      S_PU0: begin
        sub_t_next = tail[sub_lvl];
        next_ra    = tail[sub_lvl];
        free_we    = 1'b1; free_wa = e; free_wd = 1'b1;
        state_next = S_PU1;
      end

      S_PU1: begin
        nt_next = next_q;
        next_we = 1'b1; next_wa = e; next_wd = next_q;
        prev_we = 1'b1; prev_wa = e; prev_wd = sub_t;
        state_next = S_PU2;
      end

      S_PU2: begin
        next_we = 1'b1; next_wa = sub_t; next_wd = e;
        prev_we = 1'b1; prev_wa = (sub_t == e) ? e : nt; prev_wd = e;
        tail_next[sub_lvl] = e;
        cnt_next[sub_lvl]  = cnt[sub_lvl] + CNT_W'(1);
        state_next = ret;
      end

      S_OUT: begin
        if (rsp_ready) state_next = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule

[rtl/buddy_page_allocator_top.sv]
`timescale 1ns / 1ps
// Buddy page allocator over a 2^10-page region (11 tree levels).
// Input stream: one request per item, s_axis_tuser = op (0 allocate, 1 free).
// Output stream: one result per request, address and status.
// cfg_we/cfg_wdata load the region base address; write it only while idle.
// The engine does one request at a time. Link and free marks live in
// memories with registered reads, so each list push runs through the states
// PU0, PU1, PU2 and each unlink/pop through UL0, UL1. The engine does not
// take a new request before it is through with the last; s_axis_tready is
// high only when the engine is idle.
// Reset: after rst a clearing pass over every link entry initializes the
// link and free memories; s_axis_tready stays low during it.
// Stall: a finished result sits in the output register; the engine accepts
// the next request while it waits, but holds its own next result until the
// register is taken.
module buddy_page_allocator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // page_count[15:0], block_address[63:16], free_level[68:64], zero fill
  input  logic [71:0] s_axis_tdata,
  // op[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // result_address[47:0], status[49:48], zero fill
  output logic [55:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [bpa_pkg::ADDR_W-1:0] cfg_wdata
);
  import bpa_pkg::*;

  logic [ADDR_W-1:0] base_address;
  bpa_req_t          req;
  bpa_rsp_t          rsp, out_rsp;
  logic              rsp_valid, rsp_ready;

  // Base register
  always_ff @(posedge clk) begin
    if (rst) base_address <= '0;
    else if (cfg_we) base_address <= cfg_wdata;
  end

  // Unpack request
  assign req.op            = s_axis_tuser;
  assign req.page_count    = s_axis_tdata[15:0];
  assign req.block_address = s_axis_tdata[63:16];
  assign req.free_level    = s_axis_tdata[68:64];

  bpa_core u_core (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (s_axis_tvalid),
    .req_ready    (s_axis_tready),
    .req          (req),
    .base_address (base_address),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .rsp          (rsp)
  );

  // Output register
  assign rsp_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (rsp_ready) m_axis_tvalid <= rsp_valid;
  end

  always_ff @(posedge clk) begin
    if (rsp_ready && rsp_valid) out_rsp <= rsp;
  end

  assign m_axis_tdata = {6'b0, out_rsp.status, out_rsp.result_address};

endmodule

[rtl/bpa_checker.sv]
`timescale 1ns / 1ps
module bpa_props (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);
  import bpa_pkg::*;

  // Status code 3 is never produced
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[49:48] != 2'd3)
    else $error("bad status code");

  // Failed requests carry a zero address
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[49:48] != STAT_OK) |-> m_axis_tdata[47:0] == '0)
    else $error("nonzero address on failure");

  // Clearing pass blocks requests right after reset
  a_clr: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("ready during clearing pass");

  // One request at a time
  a_seq: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("ready right after an accepted request");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind buddy_page_allocator_top bpa_props u_bpa_props (.*);

[tb/bpa_checker.sv]
`timescale 1ns / 1ps
module bpa_checker
  import bpa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [71:0]       s_axis_tdata,
  input  logic              s_axis_tuser,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [55:0]       m_axis_tdata,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_wdata,
  output int                fail_count,
  output int                pending
);

  typedef struct {
    logic [ADDR_W-1:0] addr;
    status_t           status;
  } alloc_result_t;

  // shadow copy of the allocator tree
  logic [ADDR_W-1:0] region_base;
  int unsigned       lnk_prev [LINKS];
  int unsigned       lnk_next [LINKS];
  bit                node_free[NODES];
  int unsigned       lvl_tail [LEVELS];
  logic [CNT_W-1:0]  lvl_cnt  [LEVELS];

  alloc_result_t expected_results[$];

  function automatic int unsigned head_entry(int unsigned l);
    return NODES + l;
  endfunction

  function automatic void set_mark(int unsigned e, bit v);
    if (e < NODES) node_free[e] = v;
  endfunction

  function automatic void list_unlink(int unsigned e, int unsigned l);
    set_mark(e, 0);
    lnk_next[lnk_prev[e]] = lnk_next[e];
    lnk_prev[lnk_next[e]] = lnk_prev[e];
    lvl_cnt[l] = lvl_cnt[l] - 1'b1;
  endfunction

  function automatic void list_push(int unsigned l, int unsigned e);
    int unsigned t;
    t = lvl_tail[l];
    set_mark(e, 1);
    lnk_next[e] = lnk_next[t];
    lnk_prev[e] = t;
    lnk_next[t] = e;
    lnk_prev[lnk_next[e]] = e;
    lvl_tail[l] = e;
    lvl_cnt[l] = lvl_cnt[l] + 1'b1;
  endfunction

  function automatic int unsigned list_pop(int unsigned l);
    int unsigned e;
    if (lvl_cnt[l] == 0) return head_entry(l);
    e = lvl_tail[l];
    list_unlink(e, l);
    lvl_tail[l] = lnk_prev[e];
    return e;
  endfunction

  function automatic int unsigned buddy_node(int unsigned off);
    if (off == 0) return 0;
    return off[0] ? off + 1 : off - 1;
  endfunction

  function automatic void tree_reset();
    for (int i = 0; i < LINKS; i++) begin
      lnk_prev[i] = 0;
      lnk_next[i] = 0;
    end
    for (int i = 0; i < NODES; i++) node_free[i] = 0;
    for (int l = 0; l < LEVELS; l++) begin
      lnk_prev[head_entry(l)] = head_entry(l);
      lnk_next[head_entry(l)] = head_entry(l);
      lvl_tail[l] = head_entry(l);
      lvl_cnt[l] = '0;
    end
    list_push(0, 0);
  endfunction

  function automatic status_t predict_alloc(int unsigned pc, output logic [ADDR_W-1:0] addr);
    int unsigned k, lvl, splits, blk, fl, idx;
    logic [63:0] sum;
    addr = '0;
    if (pc == 0 || pc > (1 << MAX_ORDER)) return STAT_NO_BLOCK;
    k = 0;
    while ((1 << k) < pc) k++;
    lvl = MAX_ORDER - k;
    splits = 0;
    blk = lvl_tail[lvl];
    while (lvl > 0 && blk == head_entry(lvl)) begin
      blk = list_pop(lvl - 1);
      splits++;
      lvl--;
    end
    if (blk == head_entry(lvl) || blk >= NODES) return STAT_NO_BLOCK;
    if (splits == 0) begin
      blk = list_pop(lvl);
      if (blk >= NODES) return STAT_NO_BLOCK;
    end else begin
      for (int unsigned i = lvl; i < lvl + splits; i++) begin
        list_push(i + 1, 2 * blk + 2);
        list_push(i + 1, 2 * blk + 1);
        blk = list_pop(i + 1);
      end
    end
    fl = lvl + splits;
    idx = blk + 1 - (1 << fl);
    sum = 64'(region_base) + (64'(idx) << (REGION_SHIFT - fl));
    addr = sum[ADDR_W-1:0];
    return STAT_OK;
  endfunction

  function automatic status_t free_block(logic [ADDR_W-1:0] a, int unsigned lvl);
    logic [ADDR_W-1:0] rel;
    logic [63:0] pos;
    int unsigned off, b;
    bit go;
    if (lvl > MAX_ORDER || a < region_base) return STAT_BAD_FREE;
    if (a[PAGE_SHIFT-1:0] != '0) return STAT_BAD_FREE;
    rel = a - region_base;
    pos = 64'(rel) >> (REGION_SHIFT - lvl);
    if (pos >= (64'd1 << lvl)) return STAT_BAD_FREE;
    off = (1 << lvl) - 1 + int'(pos);
    if (node_free[off]) return STAT_BAD_FREE;
    list_push(lvl, off);
    // merge with the buddy while it is free
    b = buddy_node(off);
    go = node_free[b];
    while (go && lvl > 0) begin
      list_unlink(b, lvl);
      void'(list_pop(lvl));
      off = (off - 1) / 2;
      list_push(lvl - 1, off);
      lvl--;
      b = buddy_node(off);
      go = node_free[b] && node_free[off];
    end
    return STAT_OK;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    alloc_result_t want;
    logic [ADDR_W-1:0] got_addr;
    logic [1:0] got_status;
    if (rst) begin
      region_base = '0;
      tree_reset();
      expected_results.delete();
      fail_count = fail_count;
    end else begin
      if (cfg_we) region_base = cfg_wdata;
      // predict each accepted request
      if (s_axis_tvalid && s_axis_tready) begin
        want.addr = '0;
        if (!s_axis_tuser)
          want.status = predict_alloc(32'(s_axis_tdata[15:0]), want.addr);
        else
          want.status = free_block(s_axis_tdata[63:16], 32'(s_axis_tdata[68:64]));
        if (want.status != STAT_OK) want.addr = '0;
        expected_results.push_back(want);
      end
      // compare each accepted result
      if (m_axis_tvalid && m_axis_tready) begin
        got_addr = m_axis_tdata[47:0];
        got_status = m_axis_tdata[49:48];
        if (expected_results.size() == 0) begin
          $error("result with no request waiting: addr %h status %0d", got_addr, got_status);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got_addr !== want.addr) begin
            $error("result_address: expected %h actual %h", want.addr, got_addr);
            fail_count++;
          end
          if (got_status !== 2'(want.status)) begin
            $error("status: expected %0d actual %0d", want.status, got_status);
            fail_count++;
          end
        end
      end
    end
  end

  initial fail_count = 0;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import bpa_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct {
    logic [ADDR_W-1:0] rel;
    int unsigned       lvl;
  } live_block_t;

  typedef struct {
    logic        op;
    int unsigned lvl;
  } req_info_t;

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [71:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic cfg_we;
  logic [ADDR_W-1:0] cfg_wdata;
  int fail_count, pending;
  int cycles;
  bit hold_req;
  logic [ADDR_W-1:0] cur_base;

  live_block_t live_blocks[$];
  req_info_t   in_flight[$];

  buddy_page_allocator_top u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  bpa_checker u_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // run limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic int unsigned level_of_count(int unsigned pc);
    int unsigned k;
    k = 0;
    while ((1 << k) < pc) k++;
    return MAX_ORDER - k;
  endfunction

  // track granted blocks so later frees hit real allocations
  always @(posedge clk) begin
    req_info_t info;
    live_block_t lb;
    if (!rst && m_axis_tvalid && m_axis_tready && in_flight.size() > 0) begin
      info = in_flight.pop_front();
      if (info.op == OP_ALLOC && m_axis_tdata[49:48] == 2'(STAT_OK)) begin
        lb.rel = m_axis_tdata[47:0] - cur_base;
        lb.lvl = info.lvl;
        live_blocks.push_back(lb);
      end
    end
  end

  // result side: random gaps, bursts with none, one long hold
  initial begin
    int w;
    m_axis_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        m_axis_tready <= 1'b0;
        repeat (400) @(negedge clk);
      end
      w = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) w = 0;
      if (w > 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      @(negedge clk);
    end
  end

  // one request, entered and left at a falling edge
  task automatic send_req(logic op, logic [15:0] pc, logic [ADDR_W-1:0] addr, logic [4:0] lvl);
    int w;
    req_info_t info;
    w = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) w = 0;
    if (w > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (w) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {3'b000, lvl, addr, pc};
    do @(posedge clk); while (!s_axis_tready);
    info.op = op;
    info.lvl = (op == OP_ALLOC && pc != 0) ? level_of_count(32'(pc)) : 0;
    in_flight.push_back(info);
    @(negedge clk);
  endtask

  // drain all results, let the engine settle, then write the base
  task automatic set_base(logic [ADDR_W-1:0] v);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    cur_base = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_req();
    int sel, i;
    live_block_t lb;
    logic [ADDR_W-1:0] a;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      // noise over every field bit
      send_req(1'($urandom_range(0, 1)), 16'($urandom), 48'({$urandom, $urandom}),
               5'($urandom));
    end else if (sel < 50 || live_blocks.size() == 0) begin
      if ($urandom_range(0, 9) == 0)
        send_req(OP_ALLOC, 16'($urandom_range(1, 1024)), '0, '0);
      else
        send_req(OP_ALLOC, 16'($urandom_range(1, 16)), '0, '0);
    end else begin
      i = $urandom_range(0, live_blocks.size() - 1);
      lb = live_blocks[i];
      a = cur_base + lb.rel;
      if (sel < 92) begin
        live_blocks.delete(i);
        send_req(OP_FREE, 16'($urandom), a, 5'(lb.lvl));
      end else if (sel < 96) begin
        // double free, stays in the list
        send_req(OP_FREE, '0, a, 5'(lb.lvl));
      end else begin
        // overlapping free of the parent block
        live_blocks.delete(i);
        send_req(OP_FREE, '0, a, 5'((lb.lvl > 0) ? lb.lvl - 1 : 0));
      end
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] bases[5];
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    cur_base = '0;
    hold_req = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: bad counts, whole region, exhaustion, bad frees
    send_req(OP_ALLOC, 16'd0, '0, '0);
    send_req(OP_ALLOC, 16'd1025, '0, '0);
    send_req(OP_ALLOC, 16'hFFFF, '0, '0);
    send_req(OP_ALLOC, 16'd1024, '0, '0);
    send_req(OP_ALLOC, 16'd1, '0, '0);
    send_req(OP_FREE, '0, 48'h0, 5'd11);
    send_req(OP_FREE, '0, 48'h0, 5'd31);
    send_req(OP_FREE, '0, 48'h801, 5'd0);
    send_req(OP_FREE, '0, 48'h40_0000, 5'd1);
    send_req(OP_FREE, '0, 48'hFFFF_FFFF_F000, 5'd10);
    send_req(OP_FREE, '0, 48'h1000, 5'd0);
    send_req(OP_FREE, '0, 48'h0, 5'd0);
    send_req(OP_ALLOC, 16'd1, '0, '0);
    send_req(OP_ALLOC, 16'd3, '0, '0);
    send_req(OP_ALLOC, 16'd512, '0, '0);
    send_req(OP_FREE, '0, 48'h0, 5'd10);
    send_req(OP_FREE, '0, 48'h0, 5'd10);
    send_req(OP_FREE, '0, 48'h0, 5'd8);
    send_req(OP_FREE, '0, 48'h20_0000, 5'd1);

    // sender pause until everything is back, then address below base
    set_base(48'h0000_0040_0000);
    send_req(OP_FREE, '0, 48'h0, 5'd10);
    send_req(OP_FREE, '0, 48'hFFFF_FFFF_FFFF, 5'd0);

    bases[0] = 48'h0;
    bases[1] = 48'hFFFF_FFFF_F000;
    bases[2] = 48'({$urandom, $urandom}) & 48'hFFFF_FFFF_F000;
    bases[3] = 48'hFFFF_FFFF_FFFF;
    bases[4] = 48'({$urandom, $urandom});
    for (int p = 0; p < 5; p++) begin
      set_base(bases[p]);
      for (int n = 0; n < 120; n++) begin
        if (p == 2 && n == 40) hold_req = 1;
        random_req();
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
